/* sv/sfoc_pkg.sv */
// Package for the saturating first-order controller: step codes, control word
// type, the microcode table and the Q15 rounding and saturation helpers.
// Depends on nothing; used by saturating_first_order_controller.
package sfoc_pkg;

  localparam int DataW  = 16;
  localparam int ProdW  = 2 * DataW;
  localparam int StepW  = 3;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_COEF_B0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_B1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_A1 = 2'd2;

  // Microcode step addresses
  localparam logic [StepW-1:0] STEP_IDLE   = 3'd0;
  localparam logic [StepW-1:0] STEP_MUL_B0 = 3'd1;
  localparam logic [StepW-1:0] STEP_MUL_B1 = 3'd2;
  localparam logic [StepW-1:0] STEP_MUL_A1 = 3'd3;
  localparam logic [StepW-1:0] STEP_FINISH = 3'd4;

  typedef enum logic [1:0] {
    MA_B0,
    MA_B1,
    MA_A1
  } mul_a_sel_t;

  typedef enum logic {
    MB_ERR,
    MB_DRIVE
  } mul_b_sel_t;

  typedef struct packed {
    logic             mul_en;    // register a new product
    mul_a_sel_t       mul_a;
    mul_b_sel_t       mul_b;
    logic             ld_drive;  // drive = sat(m(prod,1) + state)
    logic             ld_temp;   // temp = m(prod,1)
    logic             ld_state;  // state = sat(temp - m(prod,0))
    logic             emit;      // hand drive to the output register
    logic             wait_out;  // hold the step while the output slot is full
    logic             accept;    // offer input ready
    logic [StepW-1:0] next_acc;  // next step when an input transfer happens
    logic [StepW-1:0] next_idle; // next step otherwise
  } ctrl_t;

  function automatic ctrl_t ctrl_word(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{mul_en: 1'b0, mul_a: MA_B0, mul_b: MB_ERR, ld_drive: 1'b0, ld_temp: 1'b0,
          ld_state: 1'b0, emit: 1'b0, wait_out: 1'b0, accept: 1'b0,
          next_acc: STEP_IDLE, next_idle: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.accept    = 1'b1;
        w.next_acc  = STEP_MUL_B0;
        w.next_idle = STEP_IDLE;
      end
      STEP_MUL_B0: begin
        w.mul_en    = 1'b1;
        w.mul_a     = MA_B0;
        w.mul_b     = MB_ERR;
        w.next_acc  = STEP_MUL_B1;
        w.next_idle = STEP_MUL_B1;
      end
      STEP_MUL_B1: begin
        w.mul_en    = 1'b1;
        w.mul_a     = MA_B1;
        w.mul_b     = MB_ERR;
        w.ld_drive  = 1'b1;
        w.next_acc  = STEP_MUL_A1;
        w.next_idle = STEP_MUL_A1;
      end
      STEP_MUL_A1: begin
        w.mul_en    = 1'b1;
        w.mul_a     = MA_A1;
        w.mul_b     = MB_DRIVE;
        w.ld_temp   = 1'b1;
        w.next_acc  = STEP_FINISH;
        w.next_idle = STEP_FINISH;
      end
      STEP_FINISH: begin
        w.ld_state  = 1'b1;
        w.emit      = 1'b1;
        w.wait_out  = 1'b1;
        w.accept    = 1'b1;
        w.next_acc  = STEP_MUL_B0;
        w.next_idle = STEP_IDLE;
      end
      default: begin
        w.next_acc  = STEP_IDLE;
        w.next_idle = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [DataW-1:0] sat16(input logic signed [ProdW:0] v);
    logic signed [DataW-1:0] r;
    if (v > (ProdW+1)'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -(ProdW+1)'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // Round, shift right by 14 (k1) or 15 (not k1), saturate.
  function automatic logic signed [DataW-1:0] round_sat(input logic signed [ProdW-1:0] p,
                                                         input logic k1);
    logic signed [ProdW:0] s;
    logic signed [ProdW:0] sh;
    s  = {p[ProdW-1], p} + (k1 ? (ProdW+1)'(8192) : (ProdW+1)'(16384));
    sh = k1 ? (s >>> 14) : (s >>> 15);
    return sat16(sh);
  endfunction

endpackage

/* sv/saturating_first_order_controller.sv */
// Saturating first-order controller: one shared 16x16 multiplier driven by a
// microcode table with a step counter. Depends on sfoc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, error_sample) moves one signed Q15
//   error sample per transfer. Output channel (out_valid/out_ready,
//   drive_value) moves one saturated drive value per input transfer, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   coef_b0 (index 0), coef_b1 (index 1) or coef_a1 (index 2); other indexes
//   are dropped. cfg_ready is always high; write only while the block is idle.
//   The drive value is loaded into the output register at the last step,
//   after the steps MUL_B0, MUL_B1 and MUL_A1; a new sample is taken only at
//   idle or at the last step, as the three products share one multiplier.
//   The last step also does the state update and accepts the next sample,
//   so back-to-back items run without returning to idle.
//   Reset (rst, synchronous) clears the coefficients, the integrator state,
//   the step counter and the output valid flag.
//   If the receiver stalls, the finished value waits in the output register;
//   the next item runs its products and holds at the last step until the
//   output slot frees.
module saturating_first_order_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sfoc_pkg::DataW-1:0] error_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [sfoc_pkg::DataW-1:0] drive_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfoc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic signed [sfoc_pkg::DataW-1:0] cfg_data
);
  import sfoc_pkg::*;

  // Control state
  logic [StepW-1:0] step;
  logic [StepW-1:0] step_next;
  ctrl_t            cw;

  // Coefficients and integrator state
  logic signed [DataW-1:0] coef_b0;
  logic signed [DataW-1:0] coef_b1;
  logic signed [DataW-1:0] coef_a1;
  logic signed [DataW-1:0] state;

  // Datapath registers
  logic signed [DataW-1:0] err;
  logic signed [DataW-1:0] drive;
  logic signed [DataW-1:0] temp;
  logic signed [ProdW-1:0] prod;

  logic signed [DataW-1:0] mul_a;
  logic signed [DataW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_next;
  logic signed [DataW-1:0] m_k1;
  logic signed [DataW-1:0] m_k0;
  logic signed [DataW-1:0] drive_next;
  logic signed [DataW-1:0] state_next;

  logic slot_free;
  logic advance;
  logic in_xfer;

  assign cw        = ctrl_word(step);
  assign cfg_ready = 1'b1;

  // The last step can only move on once the output register has room.
  assign slot_free = !out_valid || out_ready;
  assign advance   = !cw.wait_out || slot_free;
  assign in_ready  = cw.accept && advance;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    if (!advance) begin
      step_next = step;
    end else if (in_xfer) begin
      step_next = cw.next_acc;
    end else begin
      step_next = cw.next_idle;
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    case (cw.mul_a)
      MA_B0:   mul_a = coef_b0;
      MA_B1:   mul_a = coef_b1;
      MA_A1:   mul_a = coef_a1;
      default: mul_a = coef_b0;
    endcase
    case (cw.mul_b)
      MB_ERR:   mul_b = err;
      MB_DRIVE: mul_b = drive;
      default:  mul_b = err;
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // Post-processing of the previous product: shift 14 for the feedforward
  // terms, shift 15 for the feedback term.
  assign m_k1       = round_sat(prod, 1'b1);
  assign m_k0       = round_sat(prod, 1'b0);
  assign drive_next = sat16((ProdW+1)'(m_k1) + (ProdW+1)'(state));
  assign state_next = sat16((ProdW+1)'(temp) - (ProdW+1)'(m_k0));

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_IDLE;
      out_valid <= 1'b0;
      coef_b0   <= '0;
      coef_b1   <= '0;
      coef_a1   <= '0;
      state     <= '0;
    end else begin
      step <= step_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEF_B0: coef_b0 <= cfg_data;
          REG_COEF_B1: coef_b1 <= cfg_data;
          REG_COEF_A1: coef_a1 <= cfg_data;
          default:     ; // drop writes to unused indexes
        endcase
      end

      // Output register: load on emit, clear once the transfer completes.
      if (cw.emit && advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cw.ld_state && advance) begin
        state <= state_next;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err <= error_sample;
    end
    if (cw.mul_en) begin
      prod <= prod_next;
    end
    if (cw.ld_drive) begin
      drive <= drive_next;
    end
    if (cw.ld_temp) begin
      temp <= m_k1;
    end
    if (cw.emit && advance) begin
      drive_value <= drive;
    end
  end

endmodule
